### rtl/bcfb_pkg.sv
// bcfb_pkg: types, constants and byte/crc helpers for the bias command frame builder
// no dependencies; imported by the front, queue, back and top level modules
package bcfb_pkg;

  localparam logic [7:0]  TRAILER      = 8'h4E;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  REC_MARK     = 8'h08;
  localparam logic [7:0]  LEN_WORD     = 8'h02;
  localparam logic [7:0]  LEN_BYTE     = 8'h01;
  localparam logic [7:0]  TAG_ENABLE   = 8'h06;
  localparam logic [7:0]  TAG_LIMIT    = 8'h07;
  localparam int          NUM_RECORDS  = 6;
  localparam int          NUM_BIAS     = 4;

  // descriptor kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BIAS = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;
  localparam logic [1:0] KIND_TAIL = 2'd3;

  // last byte index within each kind of segment
  localparam logic [3:0] LAST_HDR  = 4'd11;
  localparam logic [3:0] LAST_BIAS = 4'd4;
  localparam logic [3:0] LAST_BYTE = 4'd3;
  localparam logic [3:0] LAST_TAIL = 4'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [15:0] value;
  } seg_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h4E;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'hFF;
      4'd3:    b = 8'hFF;
      4'd7:    b = 8'hFF;
      4'd10:   b = 8'hD2;
      4'd11:   b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] last_index(input logic [1:0] kind);
    logic [3:0] n;
    unique case (kind)
      KIND_HDR:  n = LAST_HDR;
      KIND_BIAS: n = LAST_BIAS;
      KIND_BYTE: n = LAST_BYTE;
      default:   n = LAST_TAIL;
    endcase
    return n;
  endfunction

  // one byte of crc-16/xmodem, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/bcfb_front.sv
// bcfb_front: takes a request, latches it and, while the queue has room, issues one
// segment descriptor per cycle: header, enabled records, tail; depends on bcfb_pkg
module bcfb_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [5:0]             record_enable,
  input  logic [15:0]            gate_bias_1_pos,
  input  logic [15:0]            gate_bias_1_neg,
  input  logic [15:0]            gate_bias_2_pos,
  input  logic [15:0]            gate_bias_2_neg,
  input  logic [7:0]             amp_enable_value,
  input  logic [7:0]             over_temperature_limit,
  input  bcfb_pkg::queue_stat_t  q_stat,
  output logic                   push,
  output bcfb_pkg::seg_desc_t    push_desc,
  output logic                   active
);
  import bcfb_pkg::*;

  localparam logic PH_HDR = 1'b0;
  localparam logic PH_REC = 1'b1;

  logic        phase;
  logic [5:0]  mask;
  logic [15:0] bias [NUM_BIAS];
  logic [7:0]  amp_val;
  logic [7:0]  limit_val;

  logic [2:0]  sel;
  logic [5:0]  mask_next;

  // lowest pending record
  always_comb begin
    sel = 3'd0;
    for (int k = NUM_RECORDS - 1; k >= 0; k--) begin
      if (mask[k]) sel = 3'(k);
    end
    mask_next = mask & ~(6'd1 << sel);
  end

  always_comb begin
    push_desc = '0;
    unique case (phase)
      PH_HDR: push_desc.kind = KIND_HDR;
      PH_REC: begin
        if (mask == 6'd0) begin
          push_desc.kind = KIND_TAIL;
        end else if (sel == 3'd4) begin
          push_desc.kind  = KIND_BYTE;
          push_desc.tag   = TAG_ENABLE;
          push_desc.value = {8'h00, amp_val};
        end else if (sel == 3'd5) begin
          push_desc.kind  = KIND_BYTE;
          push_desc.tag   = TAG_LIMIT;
          push_desc.value = {8'h00, limit_val};
        end else begin
          push_desc.kind  = KIND_BIAS;
          push_desc.tag   = {6'd0, sel[1:0]};
          push_desc.value = bias[sel[1:0]];
        end
      end
      default: push_desc.kind = KIND_HDR;
    endcase
  end

  assign push = active && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= PH_HDR;
      mask   <= '0;
    end else if (accept) begin
      active <= 1'b1;
      phase  <= PH_HDR;
      mask   <= record_enable;
    end else if (push) begin
      if (phase == PH_HDR) begin
        phase <= PH_REC;
      end else if (mask == 6'd0) begin
        active <= 1'b0;
      end else begin
        mask <= mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bias[0]   <= gate_bias_1_pos;
      bias[1]   <= gate_bias_1_neg;
      bias[2]   <= gate_bias_2_pos;
      bias[3]   <= gate_bias_2_neg;
      amp_val   <= amp_enable_value;
      limit_val <= over_temperature_limit;
    end
  end

endmodule

### rtl/bcfb_queue.sv
// bcfb_queue: short fifo of segment descriptors between front and back
// depends on bcfb_pkg
module bcfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bcfb_pkg::seg_desc_t    push_desc,
  input  logic                   pop,
  output bcfb_pkg::seg_desc_t    head,
  output bcfb_pkg::queue_stat_t  stat
);
  import bcfb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  seg_desc_t         entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push)
    else $error("descriptor pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !pop)
    else $error("descriptor popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

### rtl/bcfb_back.sv
// bcfb_back: expands descriptors into frame bytes, one per cycle while the queue supplies
// descriptors, and keeps the running crc; depends on bcfb_pkg
module bcfb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  bcfb_pkg::seg_desc_t    head,
  input  bcfb_pkg::queue_stat_t  q_stat,
  output logic                   pop,
  output logic                   active,
  output logic                   strobe,
  output logic [7:0]             frame_byte,
  output logic                   last_byte
);
  import bcfb_pkg::*;

  seg_desc_t   cur;
  logic [3:0]  idx;
  logic [15:0] crc;
  logic [7:0]  byte_now;
  logic        at_last;

  always_comb begin
    byte_now = 8'h00;
    unique case (cur.kind)
      KIND_HDR: byte_now = hdr_byte(idx);
      KIND_BIAS: begin
        case (idx)
          4'd0:    byte_now = cur.tag;
          4'd1:    byte_now = REC_MARK;
          4'd2:    byte_now = LEN_WORD;
          4'd3:    byte_now = cur.value[7:0];
          default: byte_now = cur.value[15:8];
        endcase
      end
      KIND_BYTE: begin
        case (idx)
          4'd0:    byte_now = cur.tag;
          4'd1:    byte_now = REC_MARK;
          4'd2:    byte_now = LEN_BYTE;
          default: byte_now = cur.value[7:0];
        endcase
      end
      default: begin
        case (idx)
          4'd0:    byte_now = crc[7:0];
          4'd1:    byte_now = crc[15:8];
          default: byte_now = TRAILER;
        endcase
      end
    endcase
  end

  assign at_last = (idx == last_index(cur.kind));
  assign pop     = !q_stat.empty && (!active || at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop)          active <= 1'b1;
      else if (at_last) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      idx <= '0;
    end else if (active) begin
      idx <= idx + 1'b1;
    end
    if (active) begin
      frame_byte <= byte_now;
      last_byte  <= (cur.kind == KIND_TAIL) && at_last;
      // the opening 0x4E is left out of the crc, the tail bytes are not covered
      if (cur.kind == KIND_HDR && idx == 4'd0) crc <= '0;
      else if (cur.kind != KIND_TAIL)          crc <= crc_byte(crc, byte_now);
    end
  end

endmodule

### rtl/bias_command_frame_builder.sv
// bias_command_frame_builder: top level joining front, descriptor queue and back
// depends on bcfb_pkg, bcfb_front, bcfb_queue and bcfb_back
//
// A request is taken when start is high and busy is low. The frame follows as 15 to 43
// beats, one per cycle with no gaps, each shown for one cycle with strobe high; the receiver
// cannot stall, so every beat must be taken as it comes. The first beat appears once the
// request has passed the front, the descriptor queue and the back end's output registers,
// and busy drops as the trailer (last_byte) goes out, so the next request can be taken
// once the previous frame's trailer is out; the rate is set by the byte-per-cycle back end.
// Nothing is kept from one request to the next.
module bias_command_frame_builder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  record_enable,
  input  logic [15:0] gate_bias_1_pos,
  input  logic [15:0] gate_bias_1_neg,
  input  logic [15:0] gate_bias_2_pos,
  input  logic [15:0] gate_bias_2_neg,
  input  logic [7:0]  amp_enable_value,
  input  logic [7:0]  over_temperature_limit,
  output logic        strobe,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);
  import bcfb_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  logic        front_active;
  logic        back_active;
  seg_desc_t   push_desc;
  seg_desc_t   head;
  queue_stat_t q_stat;

  assign busy   = front_active || !q_stat.empty || back_active;
  assign accept = start && !busy;

  bcfb_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .accept                 (accept),
    .record_enable          (record_enable),
    .gate_bias_1_pos        (gate_bias_1_pos),
    .gate_bias_1_neg        (gate_bias_1_neg),
    .gate_bias_2_pos        (gate_bias_2_pos),
    .gate_bias_2_neg        (gate_bias_2_neg),
    .amp_enable_value       (amp_enable_value),
    .over_temperature_limit (over_temperature_limit),
    .q_stat                 (q_stat),
    .push                   (push),
    .push_desc              (push_desc),
    .active                 (front_active)
  );

  bcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  bcfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .active     (back_active),
    .strobe     (strobe),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  a_gap_after_trailer: assert property (@(posedge clk) disable iff (rst)
    strobe && last_byte |=> !strobe)
    else $error("beat straight after the trailer");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_byte |-> busy)
    else $error("block idle while a frame is still going out");

  a_no_beat_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !strobe)
    else $error("beat right after a request was taken");

endmodule
